/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the delimiter extractor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* rtl/nde_pkg.sv */
// ----------------------------------------------------------------------------
// nde_pkg
// Types and constants shared by the nested delimiter extractor modules.
// ----------------------------------------------------------------------------
package nde_pkg;

  // Longest buffer; the byte at the last offset always ends the buffer.
  localparam int unsigned BufBytes = 65536;
  localparam int unsigned PosW     = $clog2(BufBytes);

  localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

  // Configuration register indexes.
  localparam logic [1:0] REG_OPEN_DELIM  = 2'd0;
  localparam logic [1:0] REG_OPEN_LEN    = 2'd1;
  localparam logic [1:0] REG_CLOSE_DELIM = 2'd2;
  localparam logic [1:0] REG_CLOSE_LEN   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_FOUND      = 2'd0;
  localparam logic [1:0] STATUS_NO_OPENER  = 2'd1;
  localparam logic [1:0] STATUS_UNBALANCED = 2'd2;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_MATCH  = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] open_delim;
    logic [1:0]  open_len;
    logic [15:0] close_delim;
    logic [1:0]  close_len;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    phase_t          phase;
    logic [16:0]     depth;
    logic [7:0]      prev1;     // most recent byte
    logic [7:0]      prev2;     // byte before that
    logic            skip;      // one delimiter byte still to pass over
    logic [15:0]     span_start;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] start_offset;
    logic [16:0] span_length;
  } result_t;

endpackage

/* rtl/nde_step.sv */
// ----------------------------------------------------------------------------
// nde_step
// Combinational per-byte update of the scan state and result generation.
// ----------------------------------------------------------------------------
module nde_step (
  input  nde_pkg::cfg_t        cfg,
  input  nde_pkg::scan_state_t st,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output nde_pkg::scan_state_t st_next,
  output logic                 res_valid,
  output nde_pkg::result_t     res
);
  import nde_pkg::*;

  typedef struct packed {
    scan_state_t st;
    logic        hit;
    logic [16:0] len;
  } dec_t;

  // One decision at position q. A two-byte delimiter needs the next byte.
  function automatic dec_t decide(scan_state_t s, cfg_t c, logic [15:0] q,
                                  logic [7:0] prv, logic prv_ok, logic [7:0] cur,
                                  logic [7:0] nxt, logic nxt_ok);
    dec_t d;
    logic ol2;
    logic cl2;
    logic esc;
    logic op_hit;
    logic cl_hit;
    d.st  = s;
    d.hit = 1'b0;
    d.len = '0;
    ol2 = (c.open_len != 2'd1);
    cl2 = (c.close_len != 2'd1);
    esc = prv_ok && (prv == ESCAPE_BYTE);
    op_hit = ol2 ? (nxt_ok && cur == c.open_delim[15:8] && nxt == c.open_delim[7:0])
                 : (cur == c.open_delim[7:0]);
    cl_hit = cl2 ? (nxt_ok && cur == c.close_delim[15:8] && nxt == c.close_delim[7:0])
                 : (cur == c.close_delim[7:0]);
    case (s.phase)
      PH_SEARCH: begin
        // The starting opener is taken without the escape test.
        if (op_hit) begin
          d.st.span_start = q;
          d.st.depth      = 17'd1;
          d.st.skip       = ol2;
          d.st.phase      = PH_MATCH;
        end
      end
      PH_MATCH: begin
        if (s.skip) begin
          d.st.skip = 1'b0;
        end else if (!esc && op_hit) begin
          d.st.depth = s.depth + 17'd1;
          d.st.skip  = ol2;
        end else if (!esc && cl_hit) begin
          d.st.depth = s.depth - 17'd1;
          d.st.skip  = cl2;
          if (s.depth == 17'd1) begin
            d.st.phase = PH_DONE;
            d.hit      = 1'b1;
            d.len      = {1'b0, q} + (cl2 ? 17'd2 : 17'd1) - {1'b0, s.span_start};
          end
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  logic        fin;
  logic        have_prev;
  logic        have_prev2;
  dec_t        d1;
  dec_t        d2;
  scan_state_t s1;
  logic        hit1;

  assign fin        = last_byte || (st.pos == PosW'(BufBytes - 1));
  assign have_prev  = (st.pos != '0);
  assign have_prev2 = (st.pos[PosW-1:1] != '0);

  // The decision for the previous byte, which now has its lookahead byte.
  assign d1   = decide(st, cfg, 16'(st.pos - PosW'(1)), st.prev2, have_prev2, st.prev1,
                       data_byte, 1'b1);
  assign s1   = have_prev ? d1.st : st;
  assign hit1 = have_prev && d1.hit;

  // At buffer end the final byte gets its own decision with no lookahead.
  assign d2 = decide(s1, cfg, 16'(st.pos), st.prev1, have_prev, data_byte, 8'h00, 1'b0);

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (hit1) begin
      res_valid       = 1'b1;
      res.status      = STATUS_FOUND;
      res.start_offset = s1.span_start;
      res.span_length = d1.len;
    end else if (fin) begin
      res_valid = (d2.st.phase != PH_DONE) || d2.hit;
      if (d2.hit) begin
        res.status       = STATUS_FOUND;
        res.start_offset = d2.st.span_start;
        res.span_length  = d2.len;
      end else if (d2.st.phase == PH_SEARCH) begin
        res.status = STATUS_NO_OPENER;
      end else begin
        res.status       = STATUS_UNBALANCED;
        res.start_offset = d2.st.span_start;
      end
    end
  end

  always_comb begin
    if (fin) begin
      st_next       = '0;
      st_next.phase = PH_SEARCH;
    end else begin
      st_next       = s1;
      st_next.pos   = st.pos + PosW'(1);
      st_next.prev2 = st.prev1;
      st_next.prev1 = data_byte;
    end
  end

endmodule

/* rtl/nested_delimiter_extractor_core.sv */
// ----------------------------------------------------------------------------
// nested_delimiter_extractor_core
// Finds the first balanced, escape-aware delimited span in a byte buffer.
// ----------------------------------------------------------------------------
// A result beat is derived from the accepted input beat that causes it via the
// input register, then the result register.
// Throughput: one byte per cycle while the result side is not stalled; the
// per-byte decision is combinational, between the input and result registers.
// Reset: rst is synchronous and active high; it restores the delimiter
// registers to "<<" and ">>" and starts a fresh buffer at offset 0.
module nested_delimiter_extractor_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Byte input channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] start_offset,
  output logic [16:0] span_length
);
  import nde_pkg::*;

  // Delimiter configuration. Writes are to come only while the block is idle,
  // which the block does not enforce; the step logic reads these directly.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_delim  <= 16'h3C3C;
      cfg.open_len    <= 2'd2;
      cfg.close_delim <= 16'h3E3E;
      cfg.close_len   <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPEN_DELIM:  cfg.open_delim  <= cfg_data;
        REG_OPEN_LEN:    cfg.open_len    <= cfg_data[1:0];
        REG_CLOSE_DELIM: cfg.close_delim <= cfg_data;
        REG_CLOSE_LEN:   cfg.close_len   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input register. A held beat advances whenever the result register has
  // room, so a new byte can enter every cycle the result side is not stalled.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       advance;
  logic       take;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_valid && out_free;
  assign byte_stall = in_valid && !out_free;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  // Scan state: position, phase, nesting depth and the two-byte history used
  // for the escape test and delimiter lookahead.
  scan_state_t st;
  scan_state_t st_next;
  logic        res_valid;
  result_t     res;

  nde_step u_step (
    .cfg       (cfg),
    .st        (st),
    .data_byte (in_byte),
    .last_byte (in_last),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // The all-zero state is the searching phase at offset 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register. A waiting result beat holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      status       <= res.status;
      start_offset <= res.start_offset;
      span_length  <= res.span_length;
    end
  end

endmodule

/* rtl/nde_checker.sv */
// ----------------------------------------------------------------------------
// nde_checker
// Port-level assertions for the nested delimiter extractor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nde_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [15:0] start_offset,
  input logic [16:0] span_length
);
  import nde_pkg::*;

  logic        res_wait;
  logic [34:0] res_bits;
  logic        rep_none;
  logic        rep_unbal;
  logic        rep_found;

  assign res_wait  = result_valid && result_stall;
  assign res_bits  = {status, start_offset, span_length};
  assign rep_none  = result_valid && (status == STATUS_NO_OPENER);
  assign rep_unbal = result_valid && (status == STATUS_UNBALANCED);
  assign rep_found = result_valid && (status == STATUS_FOUND);

  // A stalled result beat keeps its contents.
  `ASSERT_NEXT(a_result_hold, clk, rst, res_wait, result_valid && $stable(res_bits))

  // The input only stalls behind a result beat that the receiver holds off.
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, byte_stall, res_wait)

  // A buffer with no opener reports a zero offset and length.
  `ASSERT_IMPLIES(a_no_opener_zero, clk, rst, rep_none, {start_offset, span_length} == 33'd0)

  // An unbalanced buffer reports no length.
  `ASSERT_IMPLIES(a_unbalanced_len, clk, rst, rep_unbal, span_length == 17'd0)

  // A found span covers at least one opener byte and one closer byte.
  `ASSERT_IMPLIES(a_found_len, clk, rst, rep_found, span_length >= 17'd2)

endmodule

bind nested_delimiter_extractor_core nde_checker u_nde_checker (.*);
